// ----- hw/rtl/afs_pkg.sv -----
// Package: shared types, character codes and the Latin-1 fold table.
package afs_pkg;

  localparam int unsigned CU_W = 16;
  localparam int unsigned CH_W = 7;

  // ASCII codes used by the fold logic
  localparam logic [CH_W-1:0] CH_NONE       = 7'h00;
  localparam logic [CH_W-1:0] CH_UNDERSCORE = 7'h5F;
  localparam logic [CH_W-1:0] CH_LOWER_BIT  = 7'h20;

  // Fold entry: {first char, second char}, CH_NONE marks an absent char
  typedef logic [2*CH_W-1:0] fold_entry_t;

  localparam fold_entry_t F_NO = {CH_NONE, CH_NONE};
  localparam fold_entry_t F_A  = {7'h61, CH_NONE};
  localparam fold_entry_t F_AE = {7'h61, 7'h65};
  localparam fold_entry_t F_C  = {7'h63, CH_NONE};
  localparam fold_entry_t F_D  = {7'h64, CH_NONE};
  localparam fold_entry_t F_E  = {7'h65, CH_NONE};
  localparam fold_entry_t F_I  = {7'h69, CH_NONE};
  localparam fold_entry_t F_N  = {7'h6E, CH_NONE};
  localparam fold_entry_t F_O  = {7'h6F, CH_NONE};
  localparam fold_entry_t F_OE = {7'h6F, 7'h65};
  localparam fold_entry_t F_S  = {7'h73, CH_NONE};
  localparam fold_entry_t F_U  = {7'h75, CH_NONE};
  localparam fold_entry_t F_Y  = {7'h79, CH_NONE};
  localparam fold_entry_t F_Z  = {7'h7A, CH_NONE};

  // Folded form of units 0xC0..0xFF
  localparam fold_entry_t FOLD_LATIN1 [64] = '{
    F_A,  F_A,  F_A,  F_A,  F_A,  F_A,  F_AE, F_C,
    F_E,  F_E,  F_E,  F_E,  F_I,  F_I,  F_I,  F_I,
    F_D,  F_N,  F_O,  F_O,  F_O,  F_O,  F_O,  F_NO,
    F_O,  F_U,  F_U,  F_U,  F_U,  F_Y,  F_NO, F_S,
    F_A,  F_A,  F_A,  F_A,  F_A,  F_A,  F_AE, F_C,
    F_E,  F_E,  F_E,  F_E,  F_I,  F_I,  F_I,  F_I,
    F_O,  F_N,  F_O,  F_O,  F_O,  F_O,  F_O,  F_NO,
    F_O,  F_U,  F_U,  F_U,  F_U,  F_Y,  F_NO, F_Y
  };

  // Decoded characters for one input unit
  typedef struct packed {
    logic [1:0]      count;
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic            last_us;
  } fold_t;

endpackage

// ----- hw/rtl/afs_ifs.sv -----
// Interfaces: input unit channel and output character channel.
interface afs_in_if
  import afs_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CU_W-1:0] code_unit;
  logic            string_start;

  modport source (output valid, output code_unit, output string_start, input ready);
  modport sink   (input valid, input code_unit, input string_start, output ready);
endinterface

interface afs_out_if
  import afs_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ascii_char;
  logic            last_of_run;

  modport source (output valid, output ascii_char, output last_of_run, input ready);
  modport sink   (input valid, input ascii_char, input last_of_run, output ready);
endinterface

// ----- hw/rtl/afs_fold.sv -----
// Fold logic: maps one code unit to zero, one or two slug characters.
module afs_fold
  import afs_pkg::*;
(
  input  logic [CU_W-1:0] code_unit,
  input  logic            string_start,
  input  logic            last_us,
  output fold_t           fold
);

  logic        is_white;
  logic        is_us;
  logic        prev_us;
  fold_entry_t entry;

  // Classify whitespace
  always_comb begin
    is_white = 1'b0;
    if (code_unit >= 16'h0009 && code_unit <= 16'h000D) is_white = 1'b1;
    if (code_unit == 16'h0020 || code_unit == 16'h0085 ||
        code_unit == 16'h00A0 || code_unit == 16'h1680) is_white = 1'b1;
    if (code_unit[15:4] == 12'h200 && code_unit[3:0] <= 4'hA) is_white = 1'b1;
    if (code_unit == 16'h2028 || code_unit == 16'h2029 ||
        code_unit == 16'h202F) is_white = 1'b1;
    if (code_unit == 16'h205F || code_unit == 16'h3000) is_white = 1'b1;
  end

  assign is_us   = (code_unit == {9'd0, CH_UNDERSCORE});
  assign prev_us = last_us && !string_start;

  // Look up letter and digit folds
  always_comb begin
    entry = F_NO;
    case (code_unit)
      16'h0160, 16'h0161: entry = F_S;
      16'h0152, 16'h0153: entry = F_OE;
      16'h017D, 16'h017E: entry = F_Z;
      16'h0178, 16'h00A5: entry = F_Y;
      16'h00B5:           entry = F_U;
      default: begin
        if (code_unit[15:6] == 10'h003) begin
          entry = FOLD_LATIN1[code_unit[5:0]];
        end else if (code_unit >= 16'h0041 && code_unit <= 16'h005A) begin
          entry = {code_unit[CH_W-1:0] | CH_LOWER_BIT, CH_NONE};
        end else if ((code_unit >= 16'h0061 && code_unit <= 16'h007A) ||
                     (code_unit >= 16'h0030 && code_unit <= 16'h0039)) begin
          entry = {code_unit[CH_W-1:0], CH_NONE};
        end
      end
    endcase
  end

  // Build result: underscore collapse first, then letter fold
  always_comb begin
    fold.ch0     = entry[2*CH_W-1:CH_W];
    fold.ch1     = entry[CH_W-1:0];
    fold.last_us = prev_us;
    if (is_white || is_us) begin
      fold.ch0     = CH_UNDERSCORE;
      fold.ch1     = CH_NONE;
      fold.count   = prev_us ? 2'd0 : 2'd1;
      fold.last_us = 1'b1;
    end else if (entry[2*CH_W-1:CH_W] == CH_NONE) begin
      fold.count = 2'd0;
    end else begin
      fold.count   = (entry[CH_W-1:0] == CH_NONE) ? 2'd1 : 2'd2;
      fold.last_us = 1'b0;
    end
  end

endmodule

// ----- hw/rtl/accent_fold_slug_filter.sv -----
// Top level: slug filter with accent folding, hold stage and output register.
//
// Each beat on in_ch carries one UTF-16 code unit and yields zero, one or two
// lower-case ASCII beats on out_ch; the last one carries last_of_run. A unit
// that yields nothing is taken and leaves no trace on the output. Units that
// give zero or one character are taken one per cycle while the output keeps
// up; a ligature (ae, oe) holds the input until its second character moves
// on. The limit is the single hold register, which drains one character per
// cycle into the output register while the output keeps up. A taken unit's
// characters pass through the hold register and then the output register,
// the second of a pair behind the first. out_ch may stall freely. in_ch is
// held off while the hold register still has a second character to pass on,
// and also while its last character waits behind a stalled output;
// in_ch.ready follows out_ch.ready through combinational logic.
module accent_fold_slug_filter
  import afs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  afs_in_if.sink     in_ch,
  afs_out_if.source  out_ch
);

  fold_t           fold;
  logic            in_acc;
  logic            o_free;
  logic            move;
  logic            p_free;

  logic            last_us_r, last_us_nxt;
  logic [1:0]      p_cnt_r, p_cnt_nxt;
  logic [CH_W-1:0] p_ch0_r, p_ch0_nxt;
  logic [CH_W-1:0] p_ch1_r, p_ch1_nxt;
  logic            o_valid_r, o_valid_nxt;
  logic [CH_W-1:0] o_char_r, o_char_nxt;
  logic            o_last_r, o_last_nxt;

  afs_fold u_fold (
    .code_unit    (in_ch.code_unit),
    .string_start (in_ch.string_start),
    .last_us      (last_us_r),
    .fold         (fold)
  );

  // Handshake
  assign o_free       = !o_valid_r || out_ch.ready;
  assign move         = (p_cnt_r != 2'd0) && o_free;
  assign p_free       = (p_cnt_r == 2'd0) || (p_cnt_r == 2'd1 && move);
  assign in_ch.ready  = p_free;
  assign in_acc       = in_ch.valid && p_free;

  // Update underscore memory on every taken beat
  assign last_us_nxt = in_acc ? fold.last_us : last_us_r;

  // Hold stage: load one or two new characters, or advance past the character just sent
  always_comb begin
    p_cnt_nxt = p_cnt_r;
    p_ch0_nxt = p_ch0_r;
    p_ch1_nxt = p_ch1_r;
    if (in_acc && fold.count != 2'd0) begin
      p_cnt_nxt = fold.count;
      p_ch0_nxt = fold.ch0;
      p_ch1_nxt = fold.ch1;
    end else if (move) begin
      if (p_cnt_r == 2'd2) begin
        p_cnt_nxt = 2'd1;
        p_ch0_nxt = p_ch1_r;
      end else begin
        p_cnt_nxt = 2'd0;
      end
    end
  end

  // Output register: load from hold stage, drop when taken
  always_comb begin
    o_valid_nxt = o_valid_r;
    o_char_nxt  = o_char_r;
    o_last_nxt  = o_last_r;
    if (move) begin
      o_valid_nxt = 1'b1;
      o_char_nxt  = p_ch0_r;
      o_last_nxt  = (p_cnt_r == 2'd1);
    end else if (out_ch.ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_us_r <= 1'b0;
      p_cnt_r   <= 2'd0;
      o_valid_r <= 1'b0;
    end else begin
      last_us_r <= last_us_nxt;
      p_cnt_r   <= p_cnt_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_ch0_r  <= p_ch0_nxt;
    p_ch1_r  <= p_ch1_nxt;
    o_char_r <= o_char_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_ch.valid       = o_valid_r;
  assign out_ch.ascii_char  = o_char_r;
  assign out_ch.last_of_run = o_last_r;

  // Hold stage never counts past a pair
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_cnt_r != 2'd3)
    else $error("hold stage count out of range");

  // A ligature lands whole in the hold stage
  a_pair_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fold.count == 2'd2 |=> p_cnt_r == 2'd2)
    else $error("two-character unit not held as a pair");

  // A first-of-pair beat always has its partner waiting
  a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && !o_last_r |-> p_cnt_r == 2'd1)
    else $error("first of pair sent without its second character");

  // Emitting an underscore arms the collapse
  a_us_mem: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fold.count == 2'd1 && fold.ch0 == CH_UNDERSCORE |=> last_us_r)
    else $error("underscore memory not set after underscore beat");

endmodule
